@@ design/edge_coverage_recorder_unit_assert.svh @@
`ifndef EDGE_COVERAGE_RECORDER_UNIT_ASSERT_SVH
`define EDGE_COVERAGE_RECORDER_UNIT_ASSERT_SVH

// same-cycle implication
`define ECR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ecr_pkg.sv @@
package ecr_pkg;

    localparam logic [63:0] MIX_MUL     = 64'h2127599bf4325c37;
    localparam logic [31:0] MIX_MUL_LO  = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI  = MIX_MUL[63:32];
    localparam int          MIX_SHIFT_A = 23;
    localparam int          MIX_SHIFT_B = 47;
    localparam int          SCALE_SHIFT = 32;

    typedef enum logic [2:0] {
        CFG_TSC_BASE  = 3'd0,
        CFG_TSC_SHIFT = 3'd1,
        CFG_TSC_MULT  = 3'd2,
        CFG_SYS_TIME  = 3'd3,
        CFG_PRECISE   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic lookup;
        logic commit;
    } cov_ctrl_t;

endpackage

@@ design/ecr_cov_store.sv @@
`include "edge_coverage_recorder_unit_assert.svh"

module ecr_cov_store
    import ecr_pkg::*;
#(
    parameter  int BITMAP_BYTES = 65536,
    localparam int AW           = $clog2(BITMAP_BYTES)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cov_ctrl_t       ctrl,
    input  logic [AW-1:0]   lookup_addr,
    input  logic [7:0]      lookup_mask,
    output logic [7:0]      byte_value,
    output logic            clearing
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_BYTES - 1);

    logic [7:0]    mem [BITMAP_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    mask_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [7:0]    lw_data_reg;

    logic          pend_reg, pend_next;
    logic          lw_valid_reg, lw_valid_next;
    logic          clear_reg, clear_next;
    logic [AW-1:0] clear_cnt_reg, clear_cnt_next;
    logic          fwd_hit;

    // last write covers a read that raced the previous commit
    assign fwd_hit    = lw_valid_reg && (lw_addr_reg == addr_reg);
    assign byte_value = (fwd_hit ? lw_data_reg : rdata_reg) | mask_reg;
    assign clearing   = clear_reg;

    always_comb
    begin
        clear_next     = clear_reg && (clear_cnt_reg != LAST_ADDR);
        clear_cnt_next = clear_cnt_reg + AW'(1);
        pend_next      = ctrl.lookup | (pend_reg & ~ctrl.commit);
        lw_valid_next  = lw_valid_reg | ctrl.commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clear_cnt_reg <= clear_cnt_next;
            pend_reg      <= pend_next;
            lw_valid_reg  <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clear_cnt_reg] <= 8'd0;
        end
        else if (ctrl.commit)
        begin
            mem[addr_reg] <= byte_value;
        end
        if (ctrl.lookup)
        begin
            rdata_reg <= mem[lookup_addr];
            addr_reg  <= lookup_addr;
            mask_reg  <= lookup_mask;
        end
        if (ctrl.commit)
        begin
            lw_addr_reg <= addr_reg;
            lw_data_reg <= byte_value;
        end
    end

    `ECR_ASSERT_IMPL(a_no_access_in_clear, clear_reg, !ctrl.lookup && !ctrl.commit,
        "bitmap accessed during clearing pass")
    `ECR_ASSERT_IMPL(a_commit_needs_lookup, ctrl.commit, pend_reg,
        "commit without a pending lookup")
    `ECR_ASSERT_IMPL(a_no_lookup_overrun, ctrl.lookup && !ctrl.commit, !pend_reg,
        "lookup overwrote a pending entry")

endmodule

@@ design/edge_coverage_recorder_unit.sv @@
// Edge coverage recorder: each request is one breakpoint trap. The block hashes the trap
// address, mixes it with the hash of the previous address, sets one bit in an on-chip
// coverage bitmap and returns the updated byte; in precise mode it also returns a
// timestamped trace entry for the next ring slot. It is a six-stage pipeline that
// accepts one request per clock when nothing stalls; a request passes stage registers a,
// b, c, d and r and then the output register that drives out_valid. The rate is
// set by the bitmap read-modify-write, one memory lookup and one write-back per cycle,
// with the last write forwarded to a lookup that overlaps it. The multiplies are split
// into 32x32 partial products over two pipeline stages. After reset the bitmap is
// cleared one byte per cycle, during which in_stall is high; configuration writes are
// taken at any time and must only be issued while idle.
`include "edge_coverage_recorder_unit_assert.svh"

module edge_coverage_recorder_unit
    import ecr_pkg::*;
#(
    parameter int BITMAP_BYTES = 65536,
    parameter int TRACE_SLOTS  = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] trap_rip,
    input  logic [63:0] trap_flags,
    input  logic [63:0] cycle_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] map_byte_index,
    output logic [7:0]  map_byte_value,
    output logic        trace_valid,
    output logic [9:0]  trace_slot,
    output logic [63:0] trace_time,
    output logic [63:0] trace_pc,
    output logic [63:0] trace_flags_out,
    output logic        drain_request
);

    localparam int          AW       = $clog2(BITMAP_BYTES);
    localparam int          PW       = $clog2(TRACE_SLOTS + 1);
    localparam logic [31:0] IDX_MASK = 32'(BITMAP_BYTES * 8 - 1);

    typedef struct packed {
        logic          tv;
        logic [63:0]   pc;
        logic [63:0]   flags;
        logic [PW-1:0] slot;
        logic          drain;
    } side_t;

    typedef struct packed {
        logic [15:0] bidx;
        logic [7:0]  bval;
        logic        tv;
        logic [9:0]  slot;
        logic [63:0] ttime;
        logic [63:0] pc;
        logic [63:0] flags;
        logic        drain;
    } out_t;

    // configuration
    logic [63:0]       tsc_base_reg;
    logic signed [6:0] tsc_shift_reg;
    logic [31:0]       tsc_mult_reg;
    logic [63:0]       sys_time_reg;
    logic              precise_reg;

    // control state
    logic [PW-1:0] pos_reg, pos_next;
    logic [63:0]   prev_hash_reg, prev_hash_next;
    logic          av_reg, bv_reg, cv_reg, dv_reg, rv_reg, ov_reg;
    logic          av_next, bv_next, cv_next, dv_next, rv_next, ov_next;

    // payload
    side_t         side_a_reg, side_b_reg, side_c_reg, side_d_reg, side_r_reg;
    side_t         side_in;
    logic [63:0]   h_a_reg, dt_a_reg;
    logic [63:0]   lo_b_reg, ts_b_reg;
    logic [31:0]   cr1_b_reg, cr2_b_reg;
    logic [63:0]   hm_c_reg, tlo_c_reg, thi_c_reg;
    logic [AW-1:0] addr_d_reg;
    logic [7:0]    mask_d_reg;
    logic [15:0]   bidx_d_reg, bidx_r_reg;
    logic [63:0]   time_d_reg, time_r_reg;
    out_t          out_reg;

    // handshake
    logic rdy_o, rdy_r, rdy_d, rdy_c, rdy_b, rdy_a;
    logic load_a, load_b, load_c, load_d, load_r, load_o;

    // datapath
    logic [63:0] pc_in, h_in, ts_calc, hash_fin, time_calc;
    logic [6:0]  shr;
    logic [31:0] mixed, idx, byte32, slot32;
    logic        ring_full;
    logic [PW-1:0] slot_in;

    cov_ctrl_t   cov_ctrl;
    logic [7:0]  cov_value;
    logic        clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsc_base_reg  <= '0;
            tsc_shift_reg <= '0;
            tsc_mult_reg  <= '0;
            sys_time_reg  <= '0;
            precise_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TSC_BASE:  tsc_base_reg  <= cfg_data;
                CFG_TSC_SHIFT: tsc_shift_reg <= cfg_data[6:0];
                CFG_TSC_MULT:  tsc_mult_reg  <= cfg_data[31:0];
                CFG_SYS_TIME:  sys_time_reg  <= cfg_data;
                CFG_PRECISE:   precise_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // pipeline flow
    assign rdy_o    = !ov_reg || !out_stall;
    assign rdy_r    = !rv_reg || rdy_o;
    assign rdy_d    = !dv_reg || rdy_r;
    assign rdy_c    = !cv_reg || rdy_d;
    assign rdy_b    = !bv_reg || rdy_c;
    assign rdy_a    = !av_reg || rdy_b;
    assign in_stall = !rdy_a || clearing;
    assign load_a   = in_valid && !in_stall;
    assign load_b   = av_reg && rdy_b;
    assign load_c   = bv_reg && rdy_c;
    assign load_d   = cv_reg && rdy_d;
    assign load_r   = dv_reg && rdy_r;
    assign load_o   = rv_reg && rdy_o;

    assign cov_ctrl.lookup = load_r;
    assign cov_ctrl.commit = load_o;

    always_comb
    begin
        av_next = load_a | (av_reg & ~load_b);
        bv_next = load_b | (bv_reg & ~load_c);
        cv_next = load_c | (cv_reg & ~load_d);
        dv_next = load_d | (dv_reg & ~load_r);
        rv_next = load_r | (rv_reg & ~load_o);
        ov_next = load_o | (ov_reg & out_stall);

        // stage a inputs and ring slot
        pc_in     = trap_rip - 64'd1;
        h_in      = pc_in ^ (pc_in >> MIX_SHIFT_A);
        ring_full = pos_reg >= PW'(TRACE_SLOTS);
        slot_in   = ring_full ? '0 : pos_reg;
        pos_next  = pos_reg;
        if (load_a && precise_reg)
        begin
            pos_next = slot_in + PW'(1);
        end
        side_in.tv    = precise_reg;
        side_in.pc    = pc_in;
        side_in.flags = trap_flags;
        side_in.slot  = slot_in;
        side_in.drain = ring_full;

        // signed cycle shift
        shr = 7'(7'd0 - tsc_shift_reg);
        if (tsc_shift_reg[6])
        begin
            ts_calc = dt_a_reg >> shr;
        end
        else
        begin
            ts_calc = dt_a_reg << tsc_shift_reg[5:0];
        end

        // hash finish and bit index
        hash_fin       = hm_c_reg ^ (hm_c_reg >> MIX_SHIFT_B);
        mixed          = 32'(hash_fin ^ (prev_hash_reg << 1));
        idx            = mixed & IDX_MASK;
        byte32         = idx >> 3;
        prev_hash_next = load_d ? hash_fin : prev_hash_reg;
        time_calc      = thi_c_reg + (tlo_c_reg >> SCALE_SHIFT) + sys_time_reg;

        slot32 = 32'(side_r_reg.slot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prev_hash_reg <= '0;
            av_reg        <= 1'b0;
            bv_reg        <= 1'b0;
            cv_reg        <= 1'b0;
            dv_reg        <= 1'b0;
            rv_reg        <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            prev_hash_reg <= prev_hash_next;
            av_reg        <= av_next;
            bv_reg        <= bv_next;
            cv_reg        <= cv_next;
            dv_reg        <= dv_next;
            rv_reg        <= rv_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            side_a_reg <= side_in;
            h_a_reg    <= h_in;
            dt_a_reg   <= cycle_count - tsc_base_reg;
        end
        if (load_b)
        begin
            side_b_reg <= side_a_reg;
            lo_b_reg   <= {32'd0, h_a_reg[31:0]} * {32'd0, MIX_MUL_LO};
            cr1_b_reg  <= 32'(h_a_reg[31:0] * MIX_MUL_HI);
            cr2_b_reg  <= 32'(h_a_reg[63:32] * MIX_MUL_LO);
            ts_b_reg   <= ts_calc;
        end
        if (load_c)
        begin
            side_c_reg <= side_b_reg;
            hm_c_reg   <= lo_b_reg + {cr1_b_reg + cr2_b_reg, 32'd0};
            tlo_c_reg  <= {32'd0, ts_b_reg[31:0]} * {32'd0, tsc_mult_reg};
            thi_c_reg  <= {32'd0, ts_b_reg[63:32]} * {32'd0, tsc_mult_reg};
        end
        if (load_d)
        begin
            side_d_reg <= side_c_reg;
            addr_d_reg <= byte32[AW-1:0];
            mask_d_reg <= 8'd1 << idx[2:0];
            bidx_d_reg <= byte32[15:0];
            time_d_reg <= time_calc;
        end
        if (load_r)
        begin
            side_r_reg <= side_d_reg;
            bidx_r_reg <= bidx_d_reg;
            time_r_reg <= time_d_reg;
        end
        if (load_o)
        begin
            out_reg.bidx  <= bidx_r_reg;
            out_reg.bval  <= cov_value;
            out_reg.tv    <= side_r_reg.tv;
            out_reg.slot  <= side_r_reg.tv ? slot32[9:0] : 10'd0;
            out_reg.ttime <= side_r_reg.tv ? time_r_reg : 64'd0;
            out_reg.pc    <= side_r_reg.tv ? side_r_reg.pc : 64'd0;
            out_reg.flags <= side_r_reg.tv ? side_r_reg.flags : 64'd0;
            out_reg.drain <= side_r_reg.tv && side_r_reg.drain;
        end
    end

    ecr_cov_store #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_cov_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (cov_ctrl),
        .lookup_addr (addr_d_reg),
        .lookup_mask (mask_d_reg),
        .byte_value  (cov_value),
        .clearing    (clearing)
    );

    assign out_valid       = ov_reg;
    assign map_byte_index  = out_reg.bidx;
    assign map_byte_value  = out_reg.bval;
    assign trace_valid     = out_reg.tv;
    assign trace_slot      = out_reg.slot;
    assign trace_time      = out_reg.ttime;
    assign trace_pc        = out_reg.pc;
    assign trace_flags_out = out_reg.flags;
    assign drain_request   = out_reg.drain;

    `ECR_ASSERT_IMPL(a_ring_bound, 1'b1, pos_reg <= PW'(TRACE_SLOTS),
        "ring position beyond slot count")
    `ECR_ASSERT_NEXT(a_ring_advance, load_a && precise_reg, pos_reg != '0,
        "ring position not advanced by trace entry")
    `ECR_ASSERT_IMPL(a_drain_slot_zero, out_valid && drain_request,
        trace_valid && (trace_slot == 10'd0), "drain without wrap to slot zero")
    `ECR_ASSERT_IMPL(a_no_trace_clean, out_valid && !trace_valid,
        (trace_slot == 10'd0) && !drain_request && (trace_time == 64'd0),
        "trace fields set without trace entry")

endmodule
